### rtl/pip_pkg.sv
// shared types and constants of the point-in-polygon test block
package pip_pkg;

  localparam int PIP_MAX_VERTICES = 16;
  localparam int COORD_BITS       = 16;
  localparam int PIP_MIN_VERTICES = 3;
  localparam int PIP_DIFF_BITS    = COORD_BITS + 1;
  localparam int PIP_PROD_BITS    = 2 * PIP_DIFF_BITS;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic                         first_vertex;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    logic too_few_vertices;
    logic polygon_truncated;
  } out_result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } vertex_t;

  // one step of the shared edge unit per cycle
  typedef struct packed {
    logic load_diff;
    logic mul_first;
    logic mul_second;
  } edge_ctrl_t;

endpackage

### rtl/pip_vmem.sv
// vertex memory: one write port, one registered read port
module pip_vmem import pip_pkg::*; #(
  parameter int DEPTH = PIP_MAX_VERTICES,
  parameter int AW    = $clog2(PIP_MAX_VERTICES)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  vertex_t       wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output vertex_t       rd_data
);

  vertex_t mem [DEPTH];
  vertex_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/pip_edge_unit.sv
// shared edge unit: differences, one multiplier used twice, signed compare
module pip_edge_unit import pip_pkg::*; (
  input  logic       clk,
  input  edge_ctrl_t ctrl,
  input  vertex_t    vert_a,
  input  vertex_t    vert_b,
  input  vertex_t    point,
  output logic       edge_hit
);

  localparam int DW = PIP_DIFF_BITS;
  localparam int PW = PIP_PROD_BITS;
  localparam int MSB = COORD_BITS - 1;

  logic signed [DW-1:0] ax, ay, bx, by, px, py;
  logic signed [DW-1:0] dx_r, dy_r, ex_r, d_r;
  logic                 off_span_r, horiz_r;
  logic signed [DW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_c, prod_r, p1_r;
  logic                 d_pos, ge, le;

  assign ax = $signed({vert_a.x[MSB], vert_a.x});
  assign ay = $signed({vert_a.y[MSB], vert_a.y});
  assign bx = $signed({vert_b.x[MSB], vert_b.x});
  assign by = $signed({vert_b.y[MSB], vert_b.y});
  assign px = $signed({point.x[MSB], point.x});
  assign py = $signed({point.y[MSB], point.y});

  // first pass: (py-ay)*(bx-ax), second pass: (px-ax)*(by-ay)
  assign mul_a  = ctrl.mul_second ? ex_r : dy_r;
  assign mul_b  = ctrl.mul_second ? d_r  : dx_r;
  assign prod_c = PW'(mul_a) * PW'(mul_b);

  always_ff @(posedge clk) begin
    if (ctrl.load_diff) begin
      dx_r       <= bx - ax;
      dy_r       <= py - ay;
      ex_r       <= px - ax;
      d_r        <= by - ay;
      off_span_r <= ((ay > py) && (by > py)) || ((ay < py) && (by < py));
      horiz_r    <= (ay == by);
    end
    if (ctrl.mul_first || ctrl.mul_second) begin
      prod_r <= prod_c;
    end
    if (ctrl.mul_second) begin
      p1_r <= prod_r;
    end
  end

  assign d_pos = !d_r[DW-1];
  assign ge    = (p1_r >= prod_r);
  assign le    = (p1_r <= prod_r);

  assign edge_hit = !off_span_r && (horiz_r || (d_pos ? ge : le));

endmodule

### rtl/point_in_polygon_test_top.sv
// top level of the point-in-polygon test: vertex store, sequencer, result register
//
// Loads one polygon vertex per beat and answers point queries by the crossing
// number (even-odd) rule. A load beat (opcode 0) leaves busy low and
// gives no result; first_vertex set on a load starts a new polygon and clears
// the truncation flag. Loads past MAX_VERTICES are dropped and raise
// polygon_truncated on every later result until the next first vertex.
// A query beat (opcode 1) with n stored vertices (n >= 3) keeps busy high
// from the accepting edge until its result: S_RD0 and S_LDA fetch vertex 0,
// then each closed edge passes a memory read, a difference stage, two passes
// through the single 17x17 multiplier and the compare (S_RD to S_CMP). That
// multiplier and the single memory read port set the walk's length. With fewer
// than three vertices the result comes the cycle after the accepting edge and
// busy stays low. Each result is shown for exactly one cycle with out_strobe
// high, and there is no way to hold it off: the receiver must take it then.
// A new beat may be accepted in the same cycle that a result is shown.
module point_in_polygon_test_top import pip_pkg::*; #(
  parameter int MAX_VERTICES = PIP_MAX_VERTICES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  in_item_t    in_item,
  output logic        busy,
  output logic        out_strobe,
  output out_result_t out_result
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;  // read vertex 0
  localparam logic [2:0] S_LDA  = 3'd2;  // vertex 0 becomes edge start
  localparam logic [2:0] S_RD   = 3'd3;  // read edge end vertex
  localparam logic [2:0] S_DIF  = 3'd4;  // differences and span test
  localparam logic [2:0] S_M1   = 3'd5;  // first product
  localparam logic [2:0] S_M2   = 3'd6;  // second product
  localparam logic [2:0] S_CMP  = 3'd7;  // compare and count

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          drop_r, drop_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          parity_r, parity_nxt;
  vertex_t       point_r, point_nxt;
  vertex_t       vert_a_r, vert_a_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  out_result_t   out_res_r, out_res_nxt;

  logic          accept;
  logic [CW-1:0] base;
  logic          room;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  vertex_t       rd_data;
  vertex_t       in_vertex;
  edge_ctrl_t    edge_ctrl;
  logic          edge_hit;
  logic          last_edge;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  assign in_vertex.x = in_item.coord_x;
  assign in_vertex.y = in_item.coord_y;

  // load path: a first vertex restarts the fill from slot zero
  assign base  = in_item.first_vertex ? '0 : count_r;
  assign room  = (base < CW'(MAX_VERTICES));
  assign wr_en = accept && (in_item.opcode == OP_LOAD) && room;

  // closing edge wraps back to vertex 0
  assign last_edge = (idx_r == count_r);
  assign rd_en     = (state_r == S_RD0) || (state_r == S_RD);
  assign rd_addr   = ((state_r == S_RD0) || last_edge) ? '0 : idx_r[AW-1:0];

  assign edge_ctrl.load_diff  = (state_r == S_DIF);
  assign edge_ctrl.mul_first  = (state_r == S_M1);
  assign edge_ctrl.mul_second = (state_r == S_M2);

  pip_vmem #(
    .DEPTH (MAX_VERTICES),
    .AW    (AW)
  ) u_vmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (base[AW-1:0]),
    .wr_data (in_vertex),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pip_edge_unit u_edge (
    .clk      (clk),
    .ctrl     (edge_ctrl),
    .vert_a   (vert_a_r),
    .vert_b   (rd_data),
    .point    (point_r),
    .edge_hit (edge_hit)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    drop_nxt       = drop_r;
    idx_nxt        = idx_r;
    parity_nxt     = parity_r;
    point_nxt      = point_r;
    vert_a_nxt     = vert_a_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.opcode == OP_LOAD) begin
            if (in_item.first_vertex) begin
              drop_nxt = 1'b0;
            end
            if (room) begin
              count_nxt = base + CW'(1);
            end else begin
              drop_nxt = 1'b1;
            end
          end else if (count_r < CW'(PIP_MIN_VERTICES)) begin
            // too few vertices: answer at once, inside forced low
            out_strobe_nxt                = 1'b1;
            out_res_nxt.inside_res        = 1'b0;
            out_res_nxt.too_few_vertices  = 1'b1;
            out_res_nxt.polygon_truncated = drop_r;
          end else begin
            point_nxt  = in_vertex;
            parity_nxt = 1'b0;
            state_nxt  = S_RD0;
          end
        end
      end
      S_RD0: begin
        state_nxt = S_LDA;
      end
      S_LDA: begin
        vert_a_nxt = rd_data;
        idx_nxt    = CW'(1);
        state_nxt  = S_RD;
      end
      S_RD: begin
        state_nxt = S_DIF;
      end
      S_DIF: begin
        state_nxt = S_M1;
      end
      S_M1: begin
        state_nxt = S_M2;
      end
      S_M2: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        parity_nxt = parity_r ^ edge_hit;
        vert_a_nxt = rd_data;
        if (last_edge) begin
          out_strobe_nxt                = 1'b1;
          out_res_nxt.inside_res        = parity_r ^ edge_hit;
          out_res_nxt.too_few_vertices  = 1'b0;
          out_res_nxt.polygon_truncated = drop_r;
          state_nxt                     = S_IDLE;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      drop_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      drop_r       <= drop_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // datapath registers need no reset
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    parity_r  <= parity_nxt;
    point_r   <= point_nxt;
    vert_a_r  <= vert_a_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_res_r;

endmodule

### rtl/pip_checker.sv
// port-level checker for the point-in-polygon test, bound to the top level
module pip_checker import pip_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input in_item_t    in_item,
  input logic        busy,
  input logic        out_strobe,
  input out_result_t out_result
);

  logic load_beat, query_beat;

  assign load_beat  = start && !busy && (in_item.opcode == OP_LOAD);
  assign query_beat = start && !busy && (in_item.opcode == OP_QUERY);

  // a short polygon never reports inside
  a_too_few_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_result.too_few_vertices |-> !out_result.inside_res)
    else $error("inside reported for a polygon with too few vertices");

  // a load beat produces no result
  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    load_beat |=> !out_strobe)
    else $error("result strobe after a load beat");

  // a query either answers at once or starts the edge walk
  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    query_beat |=> (busy || out_strobe))
    else $error("query beat neither answered nor started");

  // a result is shown only once the block is free again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result strobe while busy");

  // every result follows a query beat or a finished walk
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy || query_beat))
    else $error("result strobe without a query");

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .in_item    (in_item),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_result (out_result)
);
